>>> rtl/rrq_pkg.sv
// shared command and status codes for the round-robin ready queue
package rrq_pkg;

    localparam int CMD_W  = 3;
    localparam int ID_W   = 8;
    localparam int POS_W  = 4;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TAKE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic [ID_W-1:0] MAIN_THREAD = 8'hFF;

endpackage

>>> rtl/round_robin_ready_queue_top.sv
// round-robin ready queue of thread ids with a shared address unit and a small sequencer
//
//   channel | signals                                       | beat
//   in      | in_valid, in_stall, cmd, thread_id,           | one command
//           | position, drop_current                        |
//   out     | out_valid, out_stall, status, thread_out,     | one result per command
//           | count_out                                     |
//
// queue is a circular buffer in one memory with a registered read port; every address
// goes through one wrapping adder (head plus offset), one access per cycle
// append, misc, failed: decode, push; read: decode, read, push; take, tick: decode,
// take or tick, advance, push; remove: scan (read, check), shift (read, write), push
// reset clears count, head and output valid, current thread becomes the main thread
// a command is taken only from idle; a stalled result holds and the sequencer waits on it
module round_robin_ready_queue_top
    import rrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [ID_W-1:0]   thread_id,
    input  logic [POS_W-1:0]         position,
    input  logic                     drop_current,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic signed [ID_W-1:0]   thread_out,
    output logic [CNT_W-1:0]         count_out
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_TAKE     = 4'd2;
    localparam logic [3:0] S_READ     = 4'd3;
    localparam logic [3:0] S_TICK     = 4'd4;
    localparam logic [3:0] S_ADV      = 4'd5;
    localparam logic [3:0] S_SCAN_RD  = 4'd6;
    localparam logic [3:0] S_SCAN_CK  = 4'd7;
    localparam logic [3:0] S_SHIFT_RD = 4'd8;
    localparam logic [3:0] S_SHIFT_WR = 4'd9;
    localparam logic [3:0] S_PUSH     = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [ID_W-1:0]   cur_reg, cur_next;
    logic              out_valid_reg, out_valid_next;

    logic [CW-1:0]     idx_reg, idx_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [ID_W-1:0]   tid_reg, tid_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              drop_reg, drop_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0]   res_thread_reg, res_thread_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [ID_W-1:0]   out_thread_reg, out_thread_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;

    logic [ID_W-1:0]   mem [QUEUE_DEPTH];
    logic [ID_W-1:0]   rd_data_reg;

    logic [CW-1:0]     offset;
    logic [SW-1:0]     addr_sum;
    logic [SW-1:0]     addr_wrap;
    logic [AW-1:0]     addr;
    logic              mem_we;
    logic [ID_W-1:0]   mem_wdata;

    logic              queue_empty;
    logic              queue_full;
    logic [CW-1:0]     idx_inc;
    logic [31:0]       count_ext;

    // shared wrapping address unit
    assign addr_sum  = SW'(head_reg) + SW'(offset);
    assign addr_wrap = (addr_sum >= SW'(QUEUE_DEPTH)) ? addr_sum - SW'(QUEUE_DEPTH) : addr_sum;
    assign addr      = addr_wrap[AW-1:0];

    assign queue_empty = (count_reg == '0);
    assign queue_full  = (count_reg == CW'(QUEUE_DEPTH));
    assign idx_inc     = idx_reg + CW'(1);
    assign count_ext   = 32'(count_reg);

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign thread_out = out_thread_reg;
    assign count_out  = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        out_valid_next  = out_valid_reg;
        idx_next        = idx_reg;
        cmd_next        = cmd_reg;
        tid_next        = tid_reg;
        pos_next        = pos_reg;
        drop_next       = drop_reg;
        res_status_next = res_status_reg;
        res_thread_next = res_thread_reg;
        out_status_next = out_status_reg;
        out_thread_next = out_thread_reg;
        out_count_next  = out_count_reg;
        offset          = '0;
        mem_we          = 1'b0;
        mem_wdata       = tid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    tid_next   = thread_id;
                    pos_next   = position;
                    drop_next  = drop_current;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_status_next = ST_OK;
                res_thread_next = cur_reg;
                state_next      = S_PUSH;
                unique case (cmd_reg)
                    CMD_APPEND:
                    begin
                        if (queue_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            offset     = count_reg;
                            mem_we     = 1'b1;
                            mem_wdata  = tid_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_TAKE:
                    begin
                        if (queue_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_TAKE;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (queue_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_SCAN_RD;
                        end
                    end
                    CMD_READ:
                    begin
                        if (32'(pos_reg) >= count_ext)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            offset     = CW'(pos_reg);
                            state_next = S_READ;
                        end
                    end
                    CMD_TICK:
                    begin
                        if (queue_empty)
                        begin
                            res_status_next = drop_reg ? ST_EMPTY : ST_OK;
                        end
                        else
                        begin
                            state_next = S_TICK;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_TAKE:
            begin
                res_thread_next = rd_data_reg;
                state_next      = S_ADV;
            end
            S_READ:
            begin
                res_thread_next = rd_data_reg;
                state_next      = S_PUSH;
            end
            S_TICK:
            begin
                // unless dropped, old current goes to the rear before the head moves
                res_thread_next = rd_data_reg;
                cur_next        = rd_data_reg;
                if (!drop_reg)
                begin
                    offset    = count_reg;
                    mem_we    = 1'b1;
                    mem_wdata = cur_reg;
                end
                state_next = S_ADV;
            end
            S_ADV:
            begin
                offset    = CW'(1);
                head_next = addr;
                if (cmd_reg != CMD_TICK || drop_reg)
                begin
                    count_next = count_reg - CW'(1);
                end
                state_next = S_PUSH;
            end
            S_SCAN_RD:
            begin
                offset     = idx_reg;
                state_next = S_SCAN_CK;
            end
            S_SCAN_CK:
            begin
                if (rd_data_reg == tid_reg)
                begin
                    state_next = S_SHIFT_RD;
                end
                else if (idx_inc == count_reg)
                begin
                    res_status_next = ST_EMPTY;
                    state_next      = S_PUSH;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (idx_inc == count_reg)
                begin
                    count_next      = count_reg - CW'(1);
                    res_status_next = ST_OK;
                    state_next      = S_PUSH;
                end
                else
                begin
                    offset     = idx_inc;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                offset     = idx_reg;
                mem_we     = 1'b1;
                mem_wdata  = rd_data_reg;
                idx_next   = idx_inc;
                state_next = S_SHIFT_RD;
            end
            S_PUSH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_thread_next = res_thread_reg;
                    out_count_next  = count_ext[CNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cur_reg       <= MAIN_THREAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        cmd_reg        <= cmd_next;
        tid_reg        <= tid_next;
        pos_reg        <= pos_next;
        drop_reg       <= drop_next;
        res_status_reg <= res_status_next;
        res_thread_reg <= res_thread_next;
        out_status_reg <= out_status_next;
        out_thread_reg <= out_thread_next;
        out_count_reg  <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr] <= mem_wdata;
        end
        rd_data_reg <= mem[addr];
    end

endmodule

>>> tb/tb.sv
// testbench for the round-robin ready queue: directed and random commands against a scoreboard
module tb
    import rrq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int RANDOM_CMDS = 600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_FIRST = 250;
    localparam int QUIET_LAST = 350;
    localparam logic [CMD_W-1:0] CMD_LAST = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]        op;
        logic signed [ID_W-1:0]  tid;
        logic [POS_W-1:0]        pos;
        logic                    drop;
        int                      gap;
        bit                      drain;
    } sched_cmd_t;

    typedef struct {
        logic [STAT_W-1:0]       status;
        logic signed [ID_W-1:0]  thread;
        logic [CNT_W-1:0]        count;
    } sched_reply_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [CMD_W-1:0]        cmd = '0;
    logic signed [ID_W-1:0]  thread_id = '0;
    logic [POS_W-1:0]        position = '0;
    logic                    drop_current = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [STAT_W-1:0]       status;
    logic signed [ID_W-1:0]  thread_out;
    logic [CNT_W-1:0]        count_out;

    sched_cmd_t              cmd_backlog[$];
    sched_reply_t            replies_due[$];
    logic signed [ID_W-1:0]  ready_ids[$];
    logic signed [ID_W-1:0]  running_id = MAIN_THREAD;

    sched_cmd_t              on_bus;
    sched_cmd_t              next_cmd;
    bit                      bus_busy = 1'b0;
    bit                      have_next = 1'b0;
    int                      gap_left = 0;
    int                      stall_left = 0;
    int                      replies_seen = 0;
    int                      error_count = 0;
    int                      cycles = 0;

    round_robin_ready_queue_top #(.QUEUE_DEPTH(DEPTH)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .thread_id    (thread_id),
        .position     (position),
        .drop_current (drop_current),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .thread_out   (thread_out),
        .count_out    (count_out)
    );

    always #1 clk = ~clk;

    function automatic void push_cmd(input logic [CMD_W-1:0] op, input logic signed [ID_W-1:0] tid,
                                     input logic [POS_W-1:0] pos, input logic drop,
                                     input bit drain);
        sched_cmd_t c;
        c.op = op;
        c.tid = tid;
        c.pos = pos;
        c.drop = drop;
        c.drain = drain;
        if (cmd_backlog.size() >= QUIET_FIRST && cmd_backlog.size() < QUIET_LAST)
            c.gap = 0;
        else
            c.gap = $urandom_range(0, 8);
        cmd_backlog.push_back(c);
    endfunction

    task automatic schedule_step(input sched_cmd_t c);
        sched_reply_t r;
        int i;
        int hit;
        r.status = ST_OK;
        r.thread = running_id;
        hit = -1;
        case (c.op)
            CMD_APPEND:
                if (ready_ids.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                    ready_ids.push_back(c.tid);
            CMD_TAKE:
                if (ready_ids.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.thread = ready_ids.pop_front();
            CMD_REMOVE:
            begin
                for (i = 0; i < ready_ids.size() && hit < 0; i++)
                    if (ready_ids[i] == c.tid)
                        hit = i;
                if (hit < 0)
                    r.status = ST_EMPTY;
                else
                    ready_ids.delete(hit);
            end
            CMD_READ:
                if (c.pos < ready_ids.size())
                    r.thread = ready_ids[c.pos];
                else
                    r.status = ST_EMPTY;
            CMD_TICK:
                if (c.drop)
                begin
                    if (ready_ids.size() == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        running_id = ready_ids.pop_front();
                        r.thread = running_id;
                    end
                end
                else if (ready_ids.size() != 0)
                begin
                    ready_ids.push_back(running_id);
                    running_id = ready_ids.pop_front();
                    r.thread = running_id;
                end
            default:
                ;
        endcase
        r.count = CNT_W'(ready_ids.size());
        replies_due.push_back(r);
    endtask

    // command driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                schedule_step(on_bus);
                bus_busy = 1'b0;
            end
            if (!bus_busy)
            begin
                if (!have_next && cmd_backlog.size() != 0 &&
                    (!cmd_backlog[0].drain || replies_due.size() == 0))
                begin
                    next_cmd = cmd_backlog.pop_front();
                    have_next = 1'b1;
                    gap_left = next_cmd.gap;
                end
                if (have_next && gap_left == 0)
                begin
                    cmd <= next_cmd.op;
                    thread_id <= next_cmd.tid;
                    position <= next_cmd.pos;
                    drop_current <= next_cmd.drop;
                    in_valid <= 1'b1;
                    on_bus = next_cmd;
                    bus_busy = 1'b1;
                    have_next = 1'b0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (have_next)
                        gap_left--;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        sched_reply_t exp_r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    error_count++;
                end
                else
                begin
                    exp_r = replies_due.pop_front();
                    if (status !== exp_r.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d", exp_r.status, status);
                        error_count++;
                    end
                    if (thread_out !== exp_r.thread)
                    begin
                        $error("thread_out mismatch: expected %0d, got %0d",
                               exp_r.thread, thread_out);
                        error_count++;
                    end
                    if (count_out !== exp_r.count)
                    begin
                        $error("count_out mismatch: expected %0d, got %0d",
                               exp_r.count, count_out);
                        error_count++;
                    end
                end
                replies_seen++;
                if (replies_seen >= QUIET_FIRST && replies_seen < QUIET_LAST)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 8);
            end
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left > 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int k;
        int n;
        int fill_bias;
        int r;
        logic signed [ID_W-1:0] tid;

        // empty queue corners
        push_cmd(CMD_TICK, 8'sd0, 4'd0, 1'b0, 1'b0);
        push_cmd(CMD_TICK, 8'sd0, 4'd0, 1'b1, 1'b0);
        push_cmd(CMD_TAKE, 8'sd0, 4'd0, 1'b0, 1'b0);
        push_cmd(CMD_READ, 8'sd0, 4'd15, 1'b0, 1'b0);
        push_cmd(CMD_REMOVE, -8'sd1, 4'd0, 1'b0, 1'b0);
        for (k = CMD_TICK + 1; k <= CMD_LAST; k++)
            push_cmd(CMD_W'(k), -8'sd1, 4'd15, 1'b1, 1'b0);
        // fill to the top, then overflow
        push_cmd(CMD_APPEND, 8'sd126, 4'd0, 1'b0, 1'b0);
        for (k = 0; k < DEPTH - 2; k++)
            push_cmd(CMD_APPEND, ID_W'(k), 4'd0, 1'b0, 1'b0);
        push_cmd(CMD_APPEND, -8'sd1, 4'd0, 1'b0, 1'b0);
        push_cmd(CMD_APPEND, 8'sd0, 4'd0, 1'b0, 1'b0);
        push_cmd(CMD_TICK, 8'sd0, 4'd0, 1'b0, 1'b0);
        push_cmd(CMD_READ, 8'sd0, 4'd15, 1'b0, 1'b0);
        push_cmd(CMD_REMOVE, 8'sd5, 4'd0, 1'b0, 1'b0);
        push_cmd(CMD_READ, 8'sd0, 4'd15, 1'b0, 1'b0);
        push_cmd(CMD_REMOVE, 8'sd99, 4'd0, 1'b0, 1'b0);
        push_cmd(CMD_TICK, 8'sd0, 4'd0, 1'b1, 1'b0);
        push_cmd(CMD_TAKE, 8'sd0, 4'd0, 1'b0, 1'b0);

        // random walk between empty and full
        fill_bias = 45;
        for (n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 40 == 0)
            begin
                r = $urandom_range(0, 2);
                fill_bias = (r == 0) ? 70 : ((r == 1) ? 45 : 20);
            end
            r = $urandom_range(0, 99);
            if (r < 80)
                tid = ID_W'($urandom_range(0, 15));
            else if (r < 88)
                tid = -8'sd1;
            else
                tid = ID_W'($urandom_range(0, 126));
            r = $urandom_range(0, 99);
            if (r < fill_bias)
                push_cmd(CMD_APPEND, tid, POS_W'($urandom), 1'($urandom), n % 150 == 0);
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                    push_cmd(CMD_TAKE, tid, POS_W'($urandom), 1'($urandom), n % 150 == 0);
                else if (r < 50)
                    push_cmd(CMD_REMOVE, tid, POS_W'($urandom), 1'($urandom), n % 150 == 0);
                else if (r < 72)
                    push_cmd(CMD_READ, tid, POS_W'($urandom), 1'($urandom), n % 150 == 0);
                else if (r < 97)
                    push_cmd(CMD_TICK, tid, POS_W'($urandom), 1'($urandom), n % 150 == 0);
                else
                    push_cmd(CMD_W'($urandom_range(CMD_TICK + 1, CMD_LAST)), tid,
                             POS_W'($urandom), 1'($urandom), n % 150 == 0);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || have_next || bus_busy || replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
